// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock and idle during reset.
`define EEG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock and idle during reset.
`define EEG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/eeg_pkg.sv =====
// Package with the widths, codes and types of the extended gcd block.
package eeg_pkg;

    localparam int OPERAND_WIDTH = 31;
    localparam int IN_FIELD_W    = 31;
    localparam int DIV_W         = 31;
    localparam int COEF_W        = 32;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH + 1);
    localparam int IN_DATA_W     = ((2 * IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W    = ((DIV_W + 2 * COEF_W + 7) / 8) * 8;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;

    typedef logic [OPERAND_WIDTH-1:0] t_opnd;
    typedef logic [COEF_W-1:0]        t_coef;

    // One quotient bit from the divider, most significant bit first.
    typedef struct packed {
        logic valid;
        logic bit_val;
    } t_qbit;

endpackage

// ===== hw/rtl/eeg_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, remainder at the end.
module eeg_divider import eeg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_opnd i_dividend,
    input  t_opnd i_divisor,
    output t_qbit o_qbit,
    output logic  o_done,
    output t_opnd o_rem
);

    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    t_opnd                    r_rem, n_rem;
    t_opnd                    r_quo, n_quo;
    t_opnd                    r_dvs, n_dvs;
    logic [OPERAND_WIDTH:0]   w_shift;
    logic [OPERAND_WIDTH:0]   w_trial;
    logic                     w_fit;

    assign w_shift = {r_rem, r_quo[OPERAND_WIDTH-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};
    assign w_fit   = !w_trial[OPERAND_WIDTH];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(OPERAND_WIDTH);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_fit ? w_trial[OPERAND_WIDTH-1:0] : w_shift[OPERAND_WIDTH-1:0];
            n_quo = {r_quo[OPERAND_WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_qbit.valid   = r_busy;
    assign o_qbit.bit_val = w_fit;
    assign o_done         = r_done;
    assign o_rem          = r_rem;

endmodule

// ===== hw/rtl/eeg_coef_mac.sv =====
// Accumulates quotient times coefficient from the divider's serial quotient bits.
module eeg_coef_mac import eeg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_clear,
    input  t_qbit i_qbit,
    input  t_coef i_mult,
    output t_coef o_acc
);

    t_coef r_acc, n_acc;

    // Horner form: the product builds up as quotient bits arrive high to low.
    always_comb begin
        n_acc = r_acc;
        if (i_clear) begin
            n_acc = '0;
        end else if (i_qbit.valid) begin
            n_acc = {r_acc[COEF_W-2:0], 1'b0} + (i_qbit.bit_val ? i_mult : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/extended_euclid_gcd_top.sv =====
// Extended Euclid gcd: gcd and Bezout coefficients of two operands, one word at a time.
//
// Each input word carries two non-negative operands a and b; the block returns
// g = gcd(a, b) and coefficients x, y with a*x + b*y = g (b zero gives g = a,
// x = 1, y = 0). Every Euclid step starts with a zero test and then runs
// one bit-serial division, with the quotient times coefficient products
// accumulated from the same quotient bits. Euclid takes at most about 46
// steps for 31-bit operands. The next input word is taken once the result
// has moved to the output register, even while that result still waits to
// be read.
`include "assert_macros.svh"

module extended_euclid_gcd_top import eeg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // first_operand [30:0], second_operand [61:31], zero fill above
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // divisor [30:0], coef_first [62:31], coef_second [94:63], zero fill above
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic [1:0]       r_state, n_state;
    t_opnd            r_prev_r, n_prev_r;
    t_opnd            r_cur_r, n_cur_r;
    t_coef            r_prev_s, n_prev_s;
    t_coef            r_cur_s, n_cur_s;
    t_coef            r_prev_t, n_prev_t;
    t_coef            r_cur_t, n_cur_t;
    logic             r_out_valid, n_out_valid;
    logic [DIV_W-1:0] r_out_g, n_out_g;
    t_coef            r_out_x, n_out_x;
    t_coef            r_out_y, n_out_y;

    logic             w_in_acc;
    logic             w_start;
    logic             w_done;
    logic             w_out_load;
    t_qbit            w_qbit;
    t_opnd            w_rem;
    t_coef            w_acc_s;
    t_coef            w_acc_t;

    eeg_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_prev_r),
        .i_divisor  (r_cur_r),
        .o_qbit     (w_qbit),
        .o_done     (w_done),
        .o_rem      (w_rem)
    );

    eeg_coef_mac u_mac_s (
        .i_clk   (i_clk),
        .i_clear (w_start),
        .i_qbit  (w_qbit),
        .i_mult  (r_cur_s),
        .o_acc   (w_acc_s)
    );

    eeg_coef_mac u_mac_t (
        .i_clk   (i_clk),
        .i_clear (w_start),
        .i_qbit  (w_qbit),
        .i_mult  (r_cur_t),
        .o_acc   (w_acc_t)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state     = r_state;
        n_prev_r    = r_prev_r;
        n_cur_r     = r_cur_r;
        n_prev_s    = r_prev_s;
        n_cur_s     = r_cur_s;
        n_prev_t    = r_prev_t;
        n_cur_t     = r_cur_t;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_g     = r_out_g;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        w_start     = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_prev_r = OPERAND_WIDTH'(i_s_tdata[IN_FIELD_W-1:0]);
                    n_cur_r  = OPERAND_WIDTH'(i_s_tdata[2*IN_FIELD_W-1:IN_FIELD_W]);
                    n_prev_s = COEF_W'(1);
                    n_cur_s  = '0;
                    n_prev_t = '0;
                    n_cur_t  = COEF_W'(1);
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_cur_r == '0) begin
                    // Finished; hand the result over once the output register is free.
                    if (!r_out_valid || i_m_tready) begin
                        w_out_load  = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_g     = DIV_W'(r_prev_r);
                        n_out_x     = r_prev_s;
                        n_out_y     = r_prev_t;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    w_start = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_done) begin
                    n_prev_r = r_cur_r;
                    n_cur_r  = w_rem;
                    n_prev_s = r_cur_s;
                    n_cur_s  = r_prev_s - w_acc_s;
                    n_prev_t = r_cur_t;
                    n_cur_t  = r_prev_t - w_acc_t;
                    n_state  = ST_CHECK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_prev_r <= n_prev_r;
        r_cur_r  <= n_cur_r;
        r_prev_s <= n_prev_s;
        r_cur_s  <= n_cur_s;
        r_prev_t <= n_prev_t;
        r_cur_t  <= n_cur_t;
        r_out_g  <= n_out_g;
        r_out_x  <= n_out_x;
        r_out_y  <= n_out_y;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_out_y, r_out_x, r_out_g});

    `EEG_ASSERT_IMP(a_start_nonzero, w_start, (r_cur_r != '0), "division started by zero")
    `EEG_ASSERT_IMP(a_done_in_div, w_done, (r_state == ST_DIV), "divider done outside a step")
    `EEG_ASSERT_IMP(a_rem_below, w_done, (w_rem < r_cur_r), "remainder not below divisor")
    `EEG_ASSERT_IMP(a_no_overwrite, w_out_load, (!r_out_valid || i_m_tready), "result word overwritten")
    `EEG_ASSERT_NEXT(a_start_busy, w_start, (r_state == ST_DIV), "step started but not running")

endmodule
